/* hdl/lfu_cache_slot_manager_assert.svh */
// ----------------------------------------------------------------------------
// LFU cache slot manager assertion macros
// Shorthands for concurrent assertions clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef LFU_CACHE_SLOT_MANAGER_ASSERT_SVH
`define LFU_CACHE_SLOT_MANAGER_ASSERT_SVH

// Assertion that is switched off while reset is applied.
`define LFU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Assertion that is checked during reset as well.
`define LFU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* hdl/lfu_pkg.sv */
// ----------------------------------------------------------------------------
// LFU cache slot manager package
// Shared widths, defaults and types of the slot manager.
// ----------------------------------------------------------------------------
`default_nettype none

package lfu_pkg;

    localparam int CACHE_SLOTS_DEFAULT = 64;
    localparam int BLOCK_ID_W          = 24;
    localparam int SLOT_W              = 6;
    localparam int COUNT_W             = 8;
    localparam int HIT_TOTAL_W         = 32;
    localparam int S_TDATA_W           = 24;
    localparam int M_TDATA_W           = 40;

    // Result of the shared compare unit.
    typedef struct packed {
        logic eq;
        logic lt;
    } lfu_cmp_res_t;

endpackage

`default_nettype wire

/* hdl/lfu_cmp_unit.sv */
// ----------------------------------------------------------------------------
// LFU compare unit
// Shared comparator used for the tag search and the minimum count scan.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_cmp_unit (
    input  wire logic [lfu_pkg::BLOCK_ID_W-1:0] op_a,
    input  wire logic [lfu_pkg::BLOCK_ID_W-1:0] op_b,
    output lfu_pkg::lfu_cmp_res_t                res
);

    // Both relations are unsigned.
    assign res = '{eq: (op_a == op_b), lt: (op_a < op_b)};

endmodule

`default_nettype wire

/* hdl/lfu_ram.sv */
// ----------------------------------------------------------------------------
// LFU directory RAM
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_ram #(
    parameter int WIDTH = lfu_pkg::COUNT_W,
    parameter int DEPTH = lfu_pkg::CACHE_SLOTS_DEFAULT,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* hdl/lfu_cache_slot_manager.sv */
// ----------------------------------------------------------------------------
// LFU cache slot manager
// Directory of a fully associative cache with least-frequently-used
// replacement of slots.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Ports                     | Content
//  --------+-----------+---------------------------+--------------------------
//  s_      | input     | s_tvalid s_tready s_tdata | block_id[23:0]
//  m_      | output    | m_tvalid m_tready m_tdata | slot, hit, evicted,
//          |           |                           | hit_total
//
//  One request is handled at a time. A request searches the tags of the
//  filled slots; a miss on a full cache then scans every count for a victim.
//  The tag RAM and the count RAM each have a single read port and are walked
//  one entry per cycle through the shared compare unit.
//  Reset is synchronous and active low. No clearing pass follows it: the fill
//  count keeps unwritten entries of both RAMs from ever being read.
//  A stalled result is held in the output register; a new request can be
//  taken while it waits, and its result is held back until the register is
//  free.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_cache_slot_manager #(
    parameter int CACHE_SLOTS = lfu_pkg::CACHE_SLOTS_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Request channel.
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [lfu_pkg::S_TDATA_W-1:0] s_tdata,   // [23:0] block_id
    // Result channel.
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [lfu_pkg::M_TDATA_W-1:0] m_tdata    // [5:0] slot, [6] hit,
                                                          // [7] evicted,
                                                          // [39:8] hit_total
);

    localparam int IDX_W  = $clog2(CACHE_SLOTS);
    localparam int FILL_W = $clog2(CACHE_SLOTS + 1);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(CACHE_SLOTS - 1);
    localparam logic [FILL_W-1:0] SLOTS_CNT = FILL_W'(CACHE_SLOTS);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;  // waiting for a request
    localparam logic [2:0] ST_TAG    = 3'd1;  // tag search over filled slots
    localparam logic [2:0] ST_HIT_RD = 3'd2;  // read the count of the hit slot
    localparam logic [2:0] ST_HIT_WR = 3'd3;  // write back the incremented count
    localparam logic [2:0] ST_MIN    = 3'd4;  // minimum count scan for a victim
    localparam logic [2:0] ST_FILL   = 3'd5;  // write tag and count for a miss
    localparam logic [2:0] ST_RESP   = 3'd6;  // hand the result to the output

    logic [2:0]                         state_reg;
    logic [FILL_W-1:0]                  fill_reg;
    logic [IDX_W-1:0]                   scan_start_reg;
    logic [lfu_pkg::HIT_TOTAL_W-1:0]    hits_reg;
    logic                               m_tvalid_reg;
    logic [lfu_pkg::M_TDATA_W-1:0]      m_tdata_reg;

    logic [lfu_pkg::BLOCK_ID_W-1:0]     id_reg;
    logic [FILL_W-1:0]                  idx_reg;      // tag search issue index
    logic [IDX_W-1:0]                   pos_reg;      // victim scan position
    logic [FILL_W-1:0]                  issued_reg;   // victim scan reads issued
    logic                               pend_valid_reg;
    logic [IDX_W-1:0]                   pend_idx_reg;
    logic                               pend_first_reg;
    logic                               pend_last_reg;
    logic [lfu_pkg::COUNT_W-1:0]        best_val_reg;
    logic [IDX_W-1:0]                   best_idx_reg;
    logic [IDX_W-1:0]                   target_reg;
    logic                               hit_reg;
    logic                               evicted_reg;

    logic                               s_accept;
    logic                               out_free;
    logic                               tag_issue;
    logic                               min_issue;
    logic                               pend_is_last_filled;
    logic                               min_take;

    logic [lfu_pkg::BLOCK_ID_W-1:0]     tag_rd_data;
    logic [lfu_pkg::COUNT_W-1:0]        cnt_rd_data;
    logic [IDX_W-1:0]                   cnt_rd_addr;
    logic                               cnt_wr_en;
    logic [lfu_pkg::COUNT_W-1:0]        cnt_wr_data;
    logic                               tag_wr_en;
    logic [lfu_pkg::BLOCK_ID_W-1:0]     cmp_a;
    logic [lfu_pkg::BLOCK_ID_W-1:0]     cmp_b;
    lfu_pkg::lfu_cmp_res_t              cmp_res;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // Tag reads are issued in the cycle before their compare, as are count reads in
    // the victim scan; the pending bits follow the entry under compare.
    assign tag_issue = (state_reg == ST_TAG) && (idx_reg < fill_reg);
    assign min_issue = (state_reg == ST_MIN) && (issued_reg < SLOTS_CNT);
    assign pend_is_last_filled = ((FILL_W'(pend_idx_reg) + FILL_W'(1)) == fill_reg);

    // The first count read seeds the minimum; later ones replace it only when
    // strictly smaller, so the first minimum met from the start pointer wins.
    assign min_take = pend_first_reg || cmp_res.lt;

    // The compare unit is shared: tag equality in the search, count order in
    // the victim scan.
    always_comb begin
        if (state_reg == ST_TAG) begin
            cmp_a = tag_rd_data;
            cmp_b = id_reg;
        end else begin
            cmp_a = lfu_pkg::BLOCK_ID_W'(cnt_rd_data);
            cmp_b = lfu_pkg::BLOCK_ID_W'(best_val_reg);
        end
    end

    assign cnt_rd_addr = (state_reg == ST_MIN) ? pos_reg : target_reg;
    assign cnt_wr_en   = (state_reg == ST_HIT_WR) || (state_reg == ST_FILL);
    assign cnt_wr_data = (state_reg == ST_HIT_WR) ? (cnt_rd_data + lfu_pkg::COUNT_W'(1))
                                                  : lfu_pkg::COUNT_W'(1);
    assign tag_wr_en   = (state_reg == ST_FILL);

    lfu_cmp_unit u_cmp (
        .op_a (cmp_a),
        .op_b (cmp_b),
        .res  (cmp_res)
    );

    lfu_ram #(
        .WIDTH (lfu_pkg::BLOCK_ID_W),
        .DEPTH (CACHE_SLOTS)
    ) u_tag_ram (
        .aclk    (aclk),
        .wr_en   (tag_wr_en),
        .wr_addr (target_reg),
        .wr_data (id_reg),
        .rd_addr (idx_reg[IDX_W-1:0]),
        .rd_data (tag_rd_data)
    );

    lfu_ram #(
        .WIDTH (lfu_pkg::COUNT_W),
        .DEPTH (CACHE_SLOTS)
    ) u_cnt_ram (
        .aclk    (aclk),
        .wr_en   (cnt_wr_en),
        .wr_addr (target_reg),
        .wr_data (cnt_wr_data),
        .rd_addr (cnt_rd_addr),
        .rd_data (cnt_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            scan_start_reg <= '0;
            hits_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            // A new result replaces one that leaves in the same cycle.
            if ((state_reg == ST_RESP) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        id_reg         <= s_tdata[lfu_pkg::BLOCK_ID_W-1:0];
                        idx_reg        <= '0;
                        pend_valid_reg <= 1'b0;
                        if (fill_reg == '0) begin
                            // Empty directory: the first slot is taken at once.
                            target_reg  <= '0;
                            hit_reg     <= 1'b0;
                            evicted_reg <= 1'b0;
                            state_reg   <= ST_FILL;
                        end else begin
                            state_reg <= ST_TAG;
                        end
                    end
                end

                ST_TAG: begin
                    // After the last filled slot no read is issued, so the
                    // pending bit drops by itself when the scan starts.
                    pend_valid_reg <= tag_issue;
                    pend_idx_reg   <= idx_reg[IDX_W-1:0];
                    if (tag_issue) begin
                        idx_reg <= idx_reg + FILL_W'(1);
                    end
                    if (pend_valid_reg && cmp_res.eq) begin
                        target_reg <= pend_idx_reg;
                        state_reg  <= ST_HIT_RD;
                    end else if (pend_valid_reg && pend_is_last_filled) begin
                        hit_reg <= 1'b0;
                        if (fill_reg < SLOTS_CNT) begin
                            target_reg  <= fill_reg[IDX_W-1:0];
                            evicted_reg <= 1'b0;
                            state_reg   <= ST_FILL;
                        end else begin
                            pos_reg        <= scan_start_reg;
                            issued_reg     <= '0;
                            state_reg      <= ST_MIN;
                        end
                    end
                end

                ST_HIT_RD: begin
                    state_reg <= ST_HIT_WR;
                end

                ST_HIT_WR: begin
                    // The count write happens this cycle and wraps at 255.
                    hits_reg    <= hits_reg + lfu_pkg::HIT_TOTAL_W'(1);
                    hit_reg     <= 1'b1;
                    evicted_reg <= 1'b0;
                    state_reg   <= ST_RESP;
                end

                ST_MIN: begin
                    pend_valid_reg <= min_issue;
                    pend_idx_reg   <= pos_reg;
                    pend_first_reg <= (issued_reg == '0);
                    pend_last_reg  <= (issued_reg == SLOTS_CNT - FILL_W'(1));
                    if (min_issue) begin
                        pos_reg    <= (pos_reg == LAST_IDX) ? '0 : pos_reg + IDX_W'(1);
                        issued_reg <= issued_reg + FILL_W'(1);
                    end
                    if (pend_valid_reg) begin
                        if (min_take) begin
                            best_val_reg <= cnt_rd_data;
                            best_idx_reg <= pend_idx_reg;
                        end
                        if (pend_last_reg) begin
                            target_reg     <= min_take ? pend_idx_reg : best_idx_reg;
                            evicted_reg    <= 1'b1;
                            scan_start_reg <= (scan_start_reg == LAST_IDX) ? '0
                                              : scan_start_reg + IDX_W'(1);
                            state_reg      <= ST_FILL;
                        end
                    end
                end

                ST_FILL: begin
                    // Tag and a count of one are written this cycle.
                    if (!evicted_reg) begin
                        fill_reg <= fill_reg + FILL_W'(1);
                    end
                    state_reg <= ST_RESP;
                end

                ST_RESP: begin
                    if (out_free) begin
                        m_tdata_reg  <= {hits_reg, evicted_reg, hit_reg,
                                         lfu_pkg::SLOT_W'(target_reg)};
                        state_reg    <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* hdl/lfu_cache_slot_manager_chk.sv */
// ----------------------------------------------------------------------------
// LFU cache slot manager checker
// Port-level assertions on the slot manager, attached by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_cache_slot_manager_chk (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [lfu_pkg::M_TDATA_W-1:0] m_tdata
);

`include "lfu_cache_slot_manager_assert.svh"

    // No result is offered in the cycle after reset.
    `LFU_ASSERT_ALWAYS(a_reset_clears_out, !aresetn |=> !m_tvalid, "result valid after reset")

    // A stalled result keeps its content.
    `LFU_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed")

    // A result is never both a hit and an eviction.
    `LFU_ASSERT(a_hit_xor_evict, m_tvalid |-> !(m_tdata[6] && m_tdata[7]), "hit with eviction")

    // Requests are taken one at a time.
    `LFU_ASSERT(a_one_at_a_time, s_tvalid && s_tready |=> !s_tready, "ready after accept")

endmodule

bind lfu_cache_slot_manager lfu_cache_slot_manager_chk u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

/* sim/lfu_cache_slot_manager_tb.sv */
// ----------------------------------------------------------------------------
// LFU cache slot manager testbench
// Sends block requests with random gaps against a stalling result channel.
// Every accepted request is run through an in-bench model of the directory.
// Each returned slot, hit, eviction and hit total is compared in order with
// what that model expects.
// ----------------------------------------------------------------------------
module lfu_cache_slot_manager_tb;

    localparam int SLOTS        = lfu_pkg::CACHE_SLOTS_DEFAULT;
    localparam int POOL_SIZE    = 80;
    localparam int RANDOM_ITEMS = 1724;
    localparam int HAMMER_ITEMS = 260;
    localparam int DRAIN_CYCLES = 150;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int IDLE_PERCENT = 34;

    // One result transaction, laid out as on m_tdata with slot in the lowest bits.
    typedef struct packed {
        logic [lfu_pkg::HIT_TOTAL_W-1:0] hit_total;
        logic                            evicted;
        logic                            hit;
        logic [lfu_pkg::SLOT_W-1:0]      slot;
    } slot_result_t;

    // Keeps a model of the directory and the results that are still owed.
    class slot_scoreboard;
        bit [lfu_pkg::BLOCK_ID_W-1:0]  tags[SLOTS];
        bit [lfu_pkg::COUNT_W-1:0]     counts[SLOTS];
        int                            filled;
        int                            scan_ptr;
        bit [lfu_pkg::HIT_TOTAL_W-1:0] hits;
        slot_result_t                  owed_results[$];
        int                            error_count;

        function new();
            foreach (counts[i]) counts[i] = '0;
            filled      = 0;
            scan_ptr    = 0;
            hits        = '0;
            error_count = 0;
        endfunction

        // Looks a block up in the model and updates the model as the block would.
        function slot_result_t lookup_block(bit [lfu_pkg::BLOCK_ID_W-1:0] id);
            slot_result_t              r;
            int                        victim;
            int                        pos;
            bit [lfu_pkg::COUNT_W-1:0] least;
            r = '0;
            for (int i = 0; i < filled; i++) begin
                if (tags[i] == id) begin
                    counts[i]++;
                    hits++;
                    r.slot      = lfu_pkg::SLOT_W'(i);
                    r.hit       = 1'b1;
                    r.hit_total = hits;
                    return r;
                end
            end
            if (filled < SLOTS) begin
                victim = filled;
                filled++;
            end else begin
                // The first smallest count met from the rotating pointer wins.
                victim = scan_ptr;
                least  = counts[victim];
                for (int n = 1; n < SLOTS; n++) begin
                    pos = (scan_ptr + n) % SLOTS;
                    if (counts[pos] < least) begin
                        least  = counts[pos];
                        victim = pos;
                    end
                end
                scan_ptr  = (scan_ptr + 1) % SLOTS;
                r.evicted = 1'b1;
            end
            tags[victim]   = id;
            counts[victim] = lfu_pkg::COUNT_W'(1);
            r.slot         = lfu_pkg::SLOT_W'(victim);
            r.hit_total    = hits;
            return r;
        endfunction

        function void note_request(bit [lfu_pkg::S_TDATA_W-1:0] data);
            owed_results.push_back(lookup_block(data[lfu_pkg::BLOCK_ID_W-1:0]));
        endfunction

        function void check_result(bit [lfu_pkg::M_TDATA_W-1:0] data);
            slot_result_t got;
            slot_result_t want;
            got = data;
            if (owed_results.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result: slot=%0d hit=%0b evicted=%0b hit_total=%0d",
                             got.slot, got.hit, got.evicted, got.hit_total);
                return;
            end
            want = owed_results.pop_front();
            if (got.slot !== want.slot || got.hit !== want.hit ||
                got.evicted !== want.evicted || got.hit_total !== want.hit_total) begin
                error_count++;
                if (error_count <= 10)
                    $display("mismatch: expected slot=%0d hit=%0b evicted=%0b hit_total=%0d, %s",
                             want.slot, want.hit, want.evicted, want.hit_total,
                             $sformatf("got slot=%0d hit=%0b evicted=%0b hit_total=%0d",
                                       got.slot, got.hit, got.evicted, got.hit_total));
            end
        endfunction
    endclass

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [lfu_pkg::S_TDATA_W-1:0]   s_tdata  = '0;   // [23:0] block_id
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [lfu_pkg::M_TDATA_W-1:0]   m_tdata;         // [5:0] slot, [6] hit,
                                                      // [7] evicted, [39:8] hit_total

    // While set, neither side inserts gaps or stalls.
    bit             steady_run  = 1'b0;
    int unsigned    cycle_count = 0;
    slot_scoreboard sb;

    lfu_cache_slot_manager #(
        .CACHE_SLOTS(SLOTS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // The result side stalls at random except during the steady stretch.
    always @(posedge aclk) begin
        m_tready <= steady_run || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Both channels are watched at the same edge. A request is noted before
    // any result is checked, although no result can return that fast.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    // Offers one request, with a random gap in front of it, and returns at the
    // edge where the transaction is accepted. Valid stays high when the next
    // request follows with no gap.
    task automatic send_request(input bit [lfu_pkg::BLOCK_ID_W-1:0] id);
        while (!steady_run && $urandom_range(99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= id;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Hard stop in case the block hangs.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        bit [lfu_pkg::BLOCK_ID_W-1:0] pool[POOL_SIZE];
        bit [lfu_pkg::BLOCK_ID_W-1:0] directed_ids[$];
        bit [lfu_pkg::BLOCK_ID_W-1:0] last_id;
        bit [lfu_pkg::BLOCK_ID_W-1:0] next_id;
        int                           pick;

        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: the extreme block numbers, alternating bit patterns,
        // misses while room remains and hits on the first and later slots.
        directed_ids = {24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF,
                        24'h555555, 24'hAAAAAA, 24'hAAAAAA, 24'h555555,
                        24'h000001, 24'h800000, 24'h000000, 24'h800000,
                        24'h7FFFFF, 24'hFFFFFE, 24'hFFFFFF, 24'h000001};
        foreach (directed_ids[i])
            send_request(directed_ids[i]);
        last_id = directed_ids[directed_ids.size() - 1];

        // Random part. Most requests come from a pool a little larger than
        // the cache, so hits and evictions mix once the cache has filled.
        // Fresh numbers keep replacing pool entries.
        foreach (pool[i]) pool[i] = lfu_pkg::BLOCK_ID_W'($urandom_range(24'hFFFFFF));
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady_run = (n >= 1200 && n < 1500);
            if (n == 500) begin
                // Hammer one block so its use count wraps past 255 and starts
                // again from a low value, which makes it a victim candidate.
                for (int k = 0; k < HAMMER_ITEMS; k++)
                    send_request(last_id);
            end
            pick = $urandom_range(99);
            if (pick < 65) begin
                next_id = pool[$urandom_range(POOL_SIZE - 1)];
            end else if (pick < 75) begin
                next_id = last_id;
            end else begin
                next_id = lfu_pkg::BLOCK_ID_W'($urandom_range(24'hFFFFFF));
                pool[$urandom_range(POOL_SIZE - 1)] = next_id;
            end
            send_request(next_id);
            last_id = next_id;
        end
        s_tvalid   <= 1'b0;
        steady_run = 1'b0;

        while (sb.owed_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.error_count == 0 && sb.owed_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* lfu_cache_slot_manager.f */
+incdir+hdl
hdl/lfu_pkg.sv
hdl/lfu_cmp_unit.sv
hdl/lfu_ram.sv
hdl/lfu_cache_slot_manager.sv
hdl/lfu_cache_slot_manager_chk.sv
sim/lfu_cache_slot_manager_tb.sv
